FILE: rtl/cfpd_pkg.sv
// Shared constants, types and the byte-wide CRC-16-CCITT step for the packet deframer.
package cfpd_pkg;

  localparam logic [7:0]  PREAMBLE_BYTE = 8'hAA;
  localparam logic [15:0] CRC_POLY      = 16'h1021;

  // Register word indexes on the configuration port
  localparam logic REG_NULL_CMD = 1'b0;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } result_kind_t;

  // One byte through the MSB-first CRC, eight bit steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/crc_framed_packet_deframer_top.sv
// Top level of the preamble / length / CRC-16 packet deframer.
//
// Byte-stream packet deframer. Each input beat carries one received byte.
// The block hunts for the 0xAA preamble, then takes a big-endian 16-bit
// payload length, the payload (first byte is the command, the rest are
// data) and a big-endian CRC-16-CCITT (poly 0x1021, init 0, MSB first)
// computed over the payload. Every data byte goes out as a result beat with
// result_kind = 0 as soon as it arrives; after the second CRC byte one
// frame-end beat (result_kind = 1) reports the command, the data length
// (payload length minus one) and checksum_bad. An empty payload reports
// null_command_code and a data length of 0. After a frame end, good or bad,
// hunting starts again with the next byte. Rate: one byte per clock while
// in_ready is high. The frame state and the running CRC update in the cycle
// a byte is accepted, and any result lands in a single output register;
// in_ready is low only while that register holds a beat that the sink is
// not taking this cycle, and a byte's result beat is valid the next cycle.
// Configuration: null_command_code at byte address 0 (APB, no wait states),
// to be written while the stream is idle.
module crc_framed_packet_deframer_top (
  input  logic        clk,
  input  logic        rst,
  // input byte stream
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  // result stream
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [7:0]  payload_byte,
  output logic [7:0]  frame_command,
  output logic [15:0] data_count,
  output logic        checksum_bad,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Frame phases; unused codes behave as hunting
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_COMMAND = 3'd3,
    PH_DATA    = 3'd4,
    PH_CRC_HI  = 3'd5,
    PH_CRC_LO  = 3'd6
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] payload_length, payload_length_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  held_command, held_command_next;
  logic [7:0]  received_crc_high, received_crc_high_next;
  logic [7:0]  null_command_code;

  // result computed for the byte on the input this cycle
  logic                  emit;
  cfpd_pkg::result_kind_t kind_next;
  logic [7:0]            payload_byte_next;
  logic [7:0]            frame_command_next;
  logic [15:0]           data_count_next;
  logic                  checksum_bad_next;

  logic        in_fire;
  logic        cfg_wr;
  logic [15:0] bytes_inc;
  logic [15:0] len_lo_value;
  logic [15:0] crc_byte;
  logic        empty_frame;

  // output register frees up when its beat is taken
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == cfpd_pkg::REG_NULL_CMD);
  assign prdata = (paddr[2] == cfpd_pkg::REG_NULL_CMD) ? {24'd0, null_command_code} : 32'd0;

  assign bytes_inc    = bytes_seen + 16'd1;
  assign len_lo_value = {payload_length[15:8], rx_byte};
  assign crc_byte     = cfpd_pkg::crc16_byte(running_crc, rx_byte);
  assign empty_frame  = (payload_length == 16'd0);

  always_comb begin
    phase_next             = phase;
    payload_length_next    = payload_length;
    bytes_seen_next        = bytes_seen;
    running_crc_next       = running_crc;
    held_command_next      = held_command;
    received_crc_high_next = received_crc_high;
    emit                   = 1'b0;
    kind_next              = cfpd_pkg::KIND_DATA;
    payload_byte_next      = 8'd0;
    frame_command_next     = 8'd0;
    data_count_next        = 16'd0;
    checksum_bad_next      = 1'b0;
    case (phase)
      PH_LEN_HI: begin
        payload_length_next = {rx_byte, 8'h00};
        phase_next          = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        payload_length_next = len_lo_value;
        bytes_seen_next     = 16'd0;
        running_crc_next    = 16'd0;
        phase_next          = (len_lo_value == 16'd0) ? PH_CRC_HI : PH_COMMAND;
      end
      PH_COMMAND: begin
        held_command_next = rx_byte;
        running_crc_next  = crc_byte;
        bytes_seen_next   = 16'd1;
        phase_next        = (payload_length == 16'd1) ? PH_CRC_HI : PH_DATA;
      end
      PH_DATA: begin
        running_crc_next  = crc_byte;
        bytes_seen_next   = bytes_inc;
        if (bytes_inc == payload_length) begin
          phase_next = PH_CRC_HI;
        end
        emit              = 1'b1;
        kind_next         = cfpd_pkg::KIND_DATA;
        payload_byte_next = rx_byte;
      end
      PH_CRC_HI: begin
        received_crc_high_next = rx_byte;
        phase_next             = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        emit               = 1'b1;
        kind_next          = cfpd_pkg::KIND_END;
        frame_command_next = empty_frame ? null_command_code : held_command;
        data_count_next    = empty_frame ? 16'd0 : payload_length - 16'd1;
        checksum_bad_next  = ({received_crc_high, rx_byte} != running_crc);
        phase_next         = PH_HUNT;
      end
      default: begin
        phase_next = (rx_byte == cfpd_pkg::PREAMBLE_BYTE) ? PH_LEN_HI : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HUNT;
      payload_length    <= 16'd0;
      bytes_seen        <= 16'd0;
      running_crc       <= 16'd0;
      held_command      <= 8'd0;
      received_crc_high <= 8'd0;
      null_command_code <= 8'd0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_wr) begin
        null_command_code <= pwdata[7:0];
      end
      if (in_fire) begin
        phase             <= phase_next;
        payload_length    <= payload_length_next;
        bytes_seen        <= bytes_seen_next;
        running_crc       <= running_crc_next;
        held_command      <= held_command_next;
        received_crc_high <= received_crc_high_next;
        out_valid         <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded only with a new beat
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      result_kind   <= kind_next;
      payload_byte  <= payload_byte_next;
      frame_command <= frame_command_next;
      data_count    <= data_count_next;
      checksum_bad  <= checksum_bad_next;
    end
  end

endmodule

FILE: rtl/cfpd_checker.sv
// Port-level checker for the packet deframer, bound to the top level.
module cfpd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        result_kind,
  input logic [7:0]  payload_byte,
  input logic [7:0]  frame_command,
  input logic [15:0] data_count,
  input logic        checksum_bad
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
      $stable(payload_byte) && $stable(frame_command) && $stable(data_count) &&
      $stable(checksum_bad))
    else $error("result beat changed while stalled");

  // input is never blocked while the output register is empty
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // data beats carry zero frame-end fields
  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == cfpd_pkg::KIND_DATA) |->
      frame_command == 8'd0 && data_count == 16'd0 && !checksum_bad)
    else $error("data beat with frame-end fields set");

  // no beat out of reset, and no new beat without a byte in the cycle before
  a_no_invent: assert property (@(posedge clk)
    $past(rst) || ($past(!(in_valid && in_ready)) && !$past(out_valid)) |-> !out_valid)
    else $error("result beat without an accepted byte");

endmodule

bind crc_framed_packet_deframer_top cfpd_checker u_cfpd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .result_kind   (result_kind),
  .payload_byte  (payload_byte),
  .frame_command (frame_command),
  .data_count    (data_count),
  .checksum_bad  (checksum_bad)
);

FILE: tb/sv/tb_crc_framed_packet_deframer_top.sv
// Self-checking bench for the preamble/length/CRC-16 packet deframer.
`timescale 1ns / 1ps

module tb_crc_framed_packet_deframer_top;

  localparam int CLK_HALF       = 6;
  localparam int WATCHDOG_LIMIT = 3000;  // idle cycles before giving up
  localparam int LONG_HOLD      = 400;   // sink hold-off, cycles
  localparam int SETTLE_CYCLES  = 4;     // settle time once no beats are owed
  localparam int PHASE_ITEMS    = 650;   // frame bytes per random phase

  // APB byte addresses: one mapped register, one hole for the ignore case
  localparam logic [2:0] NULL_CMD_ADDR = {cfpd_pkg::REG_NULL_CMD, 2'b00};
  localparam logic [2:0] UNMAPPED_ADDR = 3'd4;

  localparam logic APB_READ  = 1'b0;
  localparam logic APB_WRITE = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT, PH_LEN_HI, PH_LEN_LO, PH_CMD, PH_DATA, PH_CRC_HI, PH_CRC_LO
  } frame_phase_t;

  // sink ready patterns
  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_LIGHT, SINK_HEAVY} sink_mode_t;

  typedef struct packed {
    cfpd_pkg::result_kind_t kind;
    logic [7:0]   data;
    logic [7:0]   command;
    logic [15:0]  count;
    logic         bad;
  } deframe_beat_t;

  typedef logic [7:0] byte_q_t[$];

  // Tracks the deframer state per accepted byte and owes one beat per
  // data byte and per frame end.
  class deframe_scoreboard;
    frame_phase_t  phase;
    logic [15:0]   length;
    logic [15:0]   seen;
    logic [15:0]   crc;
    logic [7:0]    command;
    logic [7:0]    crc_hi;
    logic [7:0]    null_cmd;
    deframe_beat_t owed_beats[$];
    int            errors;

    function new();
      phase    = PH_HUNT;
      length   = '0;
      seen     = '0;
      crc      = '0;
      command  = '0;
      crc_hi   = '0;
      null_cmd = '0;
      errors   = 0;
    endfunction

    // MSB-first CCITT, one input bit per step
    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = {c[14:0], 1'b0};
        if (fb) begin
          c = c ^ cfpd_pkg::CRC_POLY;
        end
      end
      return c;
    endfunction

    function void write_reg(logic [2:0] addr, logic [31:0] data);
      if (addr == NULL_CMD_ADDR) begin
        null_cmd = data[7:0];
      end
    endfunction

    function void take_rx_byte(logic [7:0] b);
      deframe_beat_t beat;
      beat = '0;
      case (phase)
        PH_LEN_HI: begin
          length = {b, 8'h00};
          phase  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          length[7:0] = b;
          seen        = '0;
          crc         = '0;
          phase       = (length == 16'd0) ? PH_CRC_HI : PH_CMD;
        end
        PH_CMD: begin
          command = b;
          crc     = crc_step(crc, b);
          seen    = 16'd1;
          phase   = (length == 16'd1) ? PH_CRC_HI : PH_DATA;
        end
        PH_DATA: begin
          crc  = crc_step(crc, b);
          seen = seen + 16'd1;
          if (seen == length) begin
            phase = PH_CRC_HI;
          end
          beat.kind = cfpd_pkg::KIND_DATA;
          beat.data = b;
          owed_beats.push_back(beat);
        end
        PH_CRC_HI: begin
          crc_hi = b;
          phase  = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          beat.kind    = cfpd_pkg::KIND_END;
          beat.command = (length == 16'd0) ? null_cmd : command;
          beat.count   = (length == 16'd0) ? 16'd0 : length - 16'd1;
          beat.bad     = ({crc_hi, b} != crc);
          owed_beats.push_back(beat);
          phase = PH_HUNT;
        end
        default: begin
          phase = (b == cfpd_pkg::PREAMBLE_BYTE) ? PH_LEN_HI : PH_HUNT;
        end
      endcase
    endfunction

    function void match_result(deframe_beat_t got);
      deframe_beat_t want;
      if (owed_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat kind=%0d byte=%h cmd=%h count=%0d bad=%b",
                 $time, got.kind, got.data, got.command, got.count, got.bad);
        return;
      end
      want = owed_beats.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: beat mismatch", $time);
        $display("  expected kind=%0d byte=%h cmd=%h count=%0d bad=%b",
                 want.kind, want.data, want.command, want.count, want.bad);
        $display("  actual   kind=%0d byte=%h cmd=%h count=%0d bad=%b",
                 got.kind, got.data, got.command, got.count, got.bad);
      end
    endfunction

    function int pending();
      return owed_beats.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [7:0]  frame_command;
  logic [15:0] data_count;
  logic        checksum_bad;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  deframe_scoreboard sb = new();

  int            burst_left = 0;   // beats left in the current sender burst
  bit            hold_req   = 1'b0; // asks the sink for one long hold-off
  int            idle_cycles = 0;
  deframe_beat_t beat_seen;

  crc_framed_packet_deframer_top DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .payload_byte (payload_byte),
    .frame_command(frame_command),
    .data_count   (data_count),
    .checksum_bad (checksum_bad),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // Output side: every accepted beat goes to the scoreboard. Sampling right
  // at the rising edge sees pre-edge values of the block's registers.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      beat_seen.kind    = cfpd_pkg::result_kind_t'(result_kind);
      beat_seen.data    = payload_byte;
      beat_seen.command = frame_command;
      beat_seen.count   = data_count;
      beat_seen.bad     = checksum_bad;
      sb.match_result(beat_seen);
    end
  end

  // Watchdog: any beat on either channel or any APB activity counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Sink: ready follows a randomly chosen pattern for a random stretch;
  // one long hold-off on request lets the output register fill and stall input.
  initial begin : sink_stall
    sink_mode_t mode;
    int         mode_left;
    int         hold_left;
    mode      = SINK_OPEN;
    mode_left = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          SINK_OPEN:  out_ready = 1'b1;
          SINK_COIN:  out_ready = 1'($urandom_range(0, 1));
          SINK_LIGHT: out_ready = ($urandom_range(0, 3) != 0);
          default:    out_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Entered and left at a falling edge. valid stays high across the return
  // so back-to-back beats never drop it; a new burst may start after a gap.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid = 1'b1;
    rx_byte  = b;
    do @(posedge clk); while (!in_ready);
    sb.take_rx_byte(b);
    burst_left--;
    @(negedge clk);
  endtask

  // Preamble, big-endian length, body, big-endian CRC (xor crc_flip to corrupt)
  task automatic send_frame(input byte_q_t body, input logic [15:0] crc_flip);
    logic [15:0] len;
    logic [15:0] crc;
    len = 16'(body.size());
    crc = '0;
    foreach (body[i]) begin
      crc = deframe_scoreboard::crc_step(crc, body[i]);
    end
    crc = crc ^ crc_flip;
    send_byte(cfpd_pkg::PREAMBLE_BYTE);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    foreach (body[i]) begin
      send_byte(body[i]);
    end
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
  endtask

  // Any byte but the preamble: dropped while hunting
  task automatic send_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(0, 254));
      if (b >= cfpd_pkg::PREAMBLE_BYTE) begin
        b = b + 8'd1;
      end
      send_byte(b);
    end
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) begin
      sb.write_reg(addr, wdata);
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_null_cmd();
    logic [31:0] rd;
    apb_access(APB_READ, NULL_CMD_ADDR, '0, rd);
    if (rd[7:0] !== sb.null_cmd) begin
      sb.errors++;
      $display("%0t: null command readback expected %h actual %h",
               $time, sb.null_cmd, rd[7:0]);
    end
  endtask

  // Register writes only once the stream has drained
  task automatic program_null_cmd(input logic [7:0] code, input bit poke_hole);
    logic [31:0] rd;
    apb_access(APB_WRITE, NULL_CMD_ADDR,
               {16'($urandom_range(0, 16'hFFFF)), 8'h00, code}, rd);
    if (poke_hole) begin
      apb_access(APB_WRITE, UNMAPPED_ADDR, $urandom, rd);
    end
    check_null_cmd();
  endtask

  task automatic quiesce();
    in_valid   = 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly well-formed frames with random bodies and mostly small lengths;
  // the rest is line noise and frames with a corrupted CRC.
  task automatic run_random_traffic(input int quota);
    int          sent;
    int          pick;
    int          len;
    byte_q_t     body;
    logic [15:0] flip;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_noise($urandom_range(1, 6));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          len = 0;
        end else if (pick < 20) begin
          len = 1;
        end else if (pick < 75) begin
          len = $urandom_range(2, 12);
        end else if (pick < 95) begin
          len = $urandom_range(13, 64);
        end else begin
          len = $urandom_range(256, 400);   // nonzero length high byte
        end
        body.delete();
        repeat (len) body.push_back(8'($urandom_range(0, 255)));
        flip = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(1, 16'hFFFF)) : 16'h0000;
        send_frame(body, flip);
        sent += len + 5;
      end
    end
  endtask

  initial begin : stimulus
    byte_q_t body;
    in_valid = 1'b0;
    rx_byte  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    rst      = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset value of the null command
    check_null_cmd();

    // directed: ignored bytes, empty payload good and bad, command only,
    // data bytes including a preamble value inside the payload
    send_byte(8'h00);
    send_byte(8'hFF);
    body.delete();
    send_frame(body, 16'h0000);
    send_frame(body, 16'h1234);
    body = '{8'hFF};
    send_frame(body, 16'h0000);
    body = '{8'h00, cfpd_pkg::PREAMBLE_BYTE, 8'hFF};
    send_frame(body, 16'h0000);
    quiesce();

    program_null_cmd(8'hFF, 1'b1);
    run_random_traffic(PHASE_ITEMS);
    quiesce();

    program_null_cmd(8'($urandom_range(1, 254)), 1'b0);
    hold_req = 1'b1;  // sink stalls long while the sender keeps offering
    run_random_traffic(PHASE_ITEMS);
    quiesce();

    program_null_cmd(8'h00, 1'b0);
    run_random_traffic(PHASE_ITEMS);
    quiesce();

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
